>>> design/exon_overlap_counter_core_assert.svh
// ----------------------------------------------------------------------------
// exon_overlap_counter_core_assert
// Assertion macros used by the exon overlap counter back part (eoc_back).
// ----------------------------------------------------------------------------
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef EXON_OVERLAP_COUNTER_CORE_ASSERT_SVH
`define EXON_OVERLAP_COUNTER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define EOC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define EOC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/eoc_pkg.sv
// ----------------------------------------------------------------------------
// eoc_pkg
// Shared types and constants of the exon overlap counter.
// ----------------------------------------------------------------------------
package eoc_pkg;

  localparam int unsigned TOTAL_W = 40;
  localparam int unsigned HITS_W  = 11;
  localparam int unsigned CHROM_W = 8;
  localparam int unsigned TR_W    = 10;
  localparam int unsigned SLOT_W  = 12;
  localparam int unsigned PORT_CW = 32;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_BLOCK = 2'd1,
    ACT_READ  = 2'd2,
    ACT_CLEAR = 2'd3
  } act_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_LOAD,
    ST_READ,
    ST_RDOUT,
    ST_START,
    ST_EVAL,
    ST_UPDT,
    ST_DECIDE,
    ST_UNMARK
  } state_e;

  // One queued command after decode in the front part.
  typedef struct packed {
    act_e                 act;
    logic                 ok;      // indexes that the action uses lie within the table sizes
    logic [CHROM_W-1:0]   chrom;
    logic [PORT_CW-1:0]   rs;
    logic [PORT_CW-1:0]   re;
    logic [TR_W-1:0]      tr;
    logic [SLOT_W-1:0]    slot;
  } cmd_t;

  typedef struct packed {
    logic               valid;
    logic [CHROM_W-1:0] chrom;
    logic [TR_W-1:0]    tr;
  } owner_t;

  // Status from the back part to the front part.
  typedef struct packed {
    logic init_busy;
  } back_status_t;

endpackage

>>> design/eoc_front.sv
// ----------------------------------------------------------------------------
// eoc_front
// Accepts commands, checks their indexes and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module eoc_front #(
  parameter int unsigned MAX_EXONS       = 4096,
  parameter int unsigned MAX_TRANSCRIPTS = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [1:0]                          action_i,
  input  logic [eoc_pkg::CHROM_W-1:0]         chrom_id_i,
  input  logic [eoc_pkg::PORT_CW-1:0]         range_start_i,
  input  logic [eoc_pkg::PORT_CW-1:0]         range_end_i,
  input  logic [eoc_pkg::TR_W-1:0]            transcript_index_i,
  input  logic [eoc_pkg::SLOT_W-1:0]          exon_slot_i,
  output logic                                busy_o,
  input  eoc_pkg::back_status_t               status_i,
  output logic                                cmd_valid_o,
  output eoc_pkg::cmd_t                       cmd_o,
  input  logic                                pop_i
);
  import eoc_pkg::*;

  cmd_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       push;
  logic       slot_ok, tr_ok;
  cmd_t       cmd_new;

  assign busy_o      = (fill_q == 2'd2) || status_i.init_busy;
  assign push        = start_i && !busy_o;
  assign cmd_valid_o = (fill_q != 2'd0);
  assign cmd_o       = entry_q[rd_ptr_q];

  always_comb begin
    slot_ok = ({20'd0, exon_slot_i} < MAX_EXONS);
    tr_ok   = ({22'd0, transcript_index_i} < MAX_TRANSCRIPTS);
    cmd_new.act   = act_e'(action_i);
    cmd_new.chrom = chrom_id_i;
    cmd_new.rs    = range_start_i;
    cmd_new.re    = range_end_i;
    cmd_new.tr    = transcript_index_i;
    cmd_new.slot  = exon_slot_i;
    case (act_e'(action_i))
      ACT_LOAD: cmd_new.ok = slot_ok && tr_ok;
      ACT_READ: cmd_new.ok = tr_ok;
      default:  cmd_new.ok = 1'b1;
    endcase
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = !wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = !rd_ptr_q;
    end
    if (push && !pop_i) begin
      fill_d = fill_q + 2'd1;
    end else if (!push && pop_i) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

>>> design/eoc_back.sv
// ----------------------------------------------------------------------------
// eoc_back
// Command sequencer with the exon table and the transcript totals.
// ----------------------------------------------------------------------------
module eoc_back #(
  parameter int unsigned MAX_EXONS       = 4096,
  parameter int unsigned MAX_TRANSCRIPTS = 1024,
  parameter int unsigned COORD_BITS      = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_data_i,
  input  logic                          cmd_valid_i,
  input  eoc_pkg::cmd_t                 cmd_i,
  output logic                          pop_o,
  output eoc_pkg::back_status_t         status_o,
  output logic                          result_valid_o,
  output logic [eoc_pkg::TOTAL_W-1:0]   count_value_o,
  output logic [eoc_pkg::HITS_W-1:0]    transcripts_hit_o,
  output logic                          counted_o
);
  import eoc_pkg::*;
`include "exon_overlap_counter_core_assert.svh"

  localparam int unsigned EW        = (MAX_EXONS > 1) ? $clog2(MAX_EXONS) : 1;
  localparam int unsigned TW        = (MAX_TRANSCRIPTS > 1) ? $clog2(MAX_TRANSCRIPTS) : 1;
  localparam int unsigned DEPTH_MAX = (MAX_EXONS > MAX_TRANSCRIPTS) ? MAX_EXONS
                                                                     : MAX_TRANSCRIPTS;
  localparam int unsigned CLW       = (DEPTH_MAX > 1) ? $clog2(DEPTH_MAX) : 1;
  localparam int unsigned CB        = COORD_BITS;

  // Memories
  logic [CB-1:0]      beg_mem [MAX_EXONS];
  logic [CB-1:0]      fin_mem [MAX_EXONS];
  owner_t             own_mem [MAX_EXONS];
  logic [TOTAL_W-1:0] tot_mem [MAX_TRANSCRIPTS];
  logic               mark_mem [MAX_TRANSCRIPTS];

  logic [CB-1:0]      beg_rd_q, fin_rd_q;
  owner_t             own_rd_q;
  logic [TOTAL_W-1:0] tot_rd_q;
  logic               mark_rd_q;

  logic [EW-1:0]      ex_addr;
  logic               ex_we, own_we;
  owner_t             own_wdata;
  logic [TW-1:0]      tot_addr, mark_addr;
  logic               tot_we, mark_we, mark_wdata;
  logic [TOTAL_W-1:0] tot_wdata;

  // Control and data registers
  state_e             state_q, state_d;
  cmd_t               cmd_q;
  logic               mode_q, init_q, pass2_q;
  logic [CLW-1:0]     cnt_q, cnt_inc;
  logic [HITS_W-1:0]  hits_q;
  logic [TR_W-1:0]    only_q, t_q;
  logic               hit_q, counted_q;
  logic [CB-1:0]      ov_q;

  logic               last_exon, last_tr, last_clr;
  logic [CB-1:0]      rs_c, re_c, a0, lo, hi, ov;
  logic               hit_eval, new_mark, go_pass2;
  logic [TOTAL_W:0]   sum;

  assign cnt_inc   = cnt_q + 1'b1;
  assign last_exon = (cnt_q == CLW'(MAX_EXONS - 1));
  assign last_tr   = (cnt_q == CLW'(MAX_TRANSCRIPTS - 1));
  assign last_clr  = (cnt_q == CLW'(DEPTH_MAX - 1));

  assign pop_o              = (state_q == ST_IDLE) && cmd_valid_i;
  assign status_o.init_busy = init_q;

  // Overlap of the block with the exon just read, and the hit, mark, sum and second-pass terms.
  always_comb begin
    rs_c = CB'(cmd_q.rs);
    re_c = CB'(cmd_q.re);
    a0   = (rs_c != '0) ? rs_c - 1'b1 : '0;
    lo   = (beg_rd_q > a0) ? beg_rd_q : a0;
    hi   = (fin_rd_q < re_c) ? fin_rd_q : re_c;
    ov   = (hi > lo) ? hi - lo : '0;
    hit_eval = own_rd_q.valid && (own_rd_q.chrom == cmd_q.chrom) && (ov != '0) &&
               (!pass2_q || mode_q || (own_rd_q.tr == only_q));
    new_mark = hit_q && !mark_rd_q;
    sum      = {1'b0, tot_rd_q} + (TOTAL_W + 1)'(ov_q);
    go_pass2 = (hits_q != '0) && (mode_q || (hits_q == HITS_W'(1)));
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.act)
            ACT_LOAD:  state_d = ST_LOAD;
            ACT_BLOCK: state_d = ST_START;
            ACT_READ:  state_d = ST_READ;
            default:   state_d = ST_CLEAR;
          endcase
        end
      end
      ST_CLEAR:  state_d = last_clr ? ST_IDLE : ST_CLEAR;
      ST_LOAD:   state_d = ST_IDLE;
      ST_READ:   state_d = ST_RDOUT;
      ST_RDOUT:  state_d = ST_IDLE;
      ST_START:  state_d = ST_EVAL;
      ST_EVAL:   state_d = ST_UPDT;
      ST_UPDT: begin
        if (last_exon) begin
          state_d = pass2_q ? ST_UNMARK : ST_DECIDE;
        end else begin
          state_d = ST_EVAL;
        end
      end
      ST_DECIDE: state_d = go_pass2 ? ST_START : ST_UNMARK;
      ST_UNMARK: state_d = last_tr ? ST_IDLE : ST_UNMARK;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Memory controls
  always_comb begin
    ex_addr    = cnt_q[EW-1:0];
    ex_we      = 1'b0;
    own_we     = 1'b0;
    own_wdata  = '0;
    tot_addr   = cnt_q[TW-1:0];
    tot_we     = 1'b0;
    tot_wdata  = '0;
    mark_addr  = cnt_q[TW-1:0];
    mark_we    = 1'b0;
    mark_wdata = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        own_we  = ({1'b0, cnt_q} < (CLW + 1)'(MAX_EXONS));
        tot_we  = ({1'b0, cnt_q} < (CLW + 1)'(MAX_TRANSCRIPTS));
        mark_we = tot_we;
      end
      ST_LOAD: begin
        ex_addr         = EW'(cmd_q.slot);
        ex_we           = cmd_q.ok;
        own_we          = cmd_q.ok;
        own_wdata.valid = 1'b1;
        own_wdata.chrom = cmd_q.chrom;
        own_wdata.tr    = cmd_q.tr;
      end
      ST_READ: tot_addr = TW'(cmd_q.tr);
      ST_START: ex_addr = '0;
      ST_EVAL: begin
        tot_addr  = TW'(own_rd_q.tr);
        mark_addr = TW'(own_rd_q.tr);
      end
      ST_UPDT: begin
        ex_addr    = cnt_inc[EW-1:0];
        tot_addr   = TW'(t_q);
        mark_addr  = TW'(t_q);
        mark_we    = !pass2_q && new_mark;
        mark_wdata = 1'b1;
        tot_we     = pass2_q && hit_q;
        tot_wdata  = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
      end
      ST_UNMARK: mark_we = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ex_we) begin
      beg_mem[ex_addr] <= CB'(cmd_q.rs);
      fin_mem[ex_addr] <= CB'(cmd_q.re);
    end
    if (own_we) begin
      own_mem[ex_addr] <= own_wdata;
    end
    beg_rd_q <= beg_mem[ex_addr];
    fin_rd_q <= fin_mem[ex_addr];
    own_rd_q <= own_mem[ex_addr];
  end

  always_ff @(posedge clk_i) begin
    if (tot_we) begin
      tot_mem[tot_addr] <= tot_wdata;
    end
    tot_rd_q <= tot_mem[tot_addr];
  end

  always_ff @(posedge clk_i) begin
    if (mark_we) begin
      mark_mem[mark_addr] <= mark_wdata;
    end
    mark_rd_q <= mark_mem[mark_addr];
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLEAR;
      init_q         <= 1'b1;
      mode_q         <= 1'b0;
      cnt_q          <= '0;
      pass2_q        <= 1'b0;
      result_valid_o <= 1'b0;
    end else begin
      state_q        <= state_d;
      result_valid_o <= 1'b0;
      if (cfg_we_i) begin
        mode_q <= cfg_data_i;
      end
      case (state_q)
        ST_IDLE: begin
          cnt_q   <= '0;
          pass2_q <= 1'b0;
        end
        ST_CLEAR: begin
          cnt_q <= cnt_inc;
          if (last_clr) begin
            result_valid_o <= !init_q;
            init_q         <= 1'b0;
          end
        end
        ST_LOAD:   result_valid_o <= 1'b1;
        ST_RDOUT:  result_valid_o <= 1'b1;
        ST_START:  cnt_q <= '0;
        ST_UPDT: begin
          cnt_q <= last_exon ? '0 : cnt_inc;
        end
        ST_DECIDE: pass2_q <= go_pass2;
        ST_UNMARK: begin
          cnt_q <= cnt_inc;
          result_valid_o <= last_tr;
        end
        default: begin
        end
      endcase
    end
  end

  // Data registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_q <= cmd_i;
        end
        hits_q    <= '0;
        counted_q <= 1'b0;
        only_q    <= '0;
      end
      ST_EVAL: begin
        hit_q <= hit_eval;
        t_q   <= own_rd_q.tr;
        ov_q  <= ov;
      end
      ST_UPDT: begin
        if (!pass2_q && new_mark) begin
          hits_q <= hits_q + 1'b1;
          only_q <= t_q;
        end
        if (pass2_q && hit_q) begin
          counted_q <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Result beat payload
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_RDOUT: begin
        count_value_o     <= cmd_q.ok ? tot_rd_q : '0;
        transcripts_hit_o <= '0;
        counted_o         <= 1'b0;
      end
      ST_UNMARK: begin
        count_value_o     <= '0;
        transcripts_hit_o <= hits_q;
        counted_o         <= counted_q;
      end
      default: begin
        count_value_o     <= '0;
        transcripts_hit_o <= '0;
        counted_o         <= 1'b0;
      end
    endcase
  end

  // Result beats never come back to back.
  `EOC_ASSERT_NEXT(a_single_beat, result_valid_o, !result_valid_o, "back-to-back result beats")
  // The adding pass only runs after some transcript was marked.
  `EOC_ASSERT_IMPL(a_pass2_hits, pass2_q && (state_q == ST_UPDT), hits_q != '0,
                   "adding pass without hits")
  // No command is taken while the power-up clear is still running.
  `EOC_ASSERT_IMPL(a_no_pop_init, init_q, !pop_o, "command taken during initial clear")

endmodule

>>> design/exon_overlap_counter_core.sv
// ----------------------------------------------------------------------------
// exon_overlap_counter_core
// Per-transcript exon overlap counter with a full-scan exon table.
// ----------------------------------------------------------------------------
// A command is taken when start_i is high and busy_o is low; every command gives one
// result beat on result_valid_o, which the receiver must take in that cycle. A clear
// walks over every exon and transcript table entry. A read block runs a marking scan
// over the exon slots, a second scan that adds overlaps if transcripts were marked (with
// mode 0, only if exactly one was), and a walk over the transcripts that drops the hit
// marks. Each exon slot in a scan takes the registered exon table read followed by the
// registered total or mark read of its transcript. After reset busy_o stays high while
// the tables are cleared. A two-entry command queue lets new commands in while one is
// being worked on.
module exon_overlap_counter_core #(
  parameter int unsigned MAX_EXONS       = 4096,
  parameter int unsigned MAX_TRANSCRIPTS = 1024,
  parameter int unsigned COORD_BITS      = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_data_i,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [1:0]                    action_i,
  input  logic [eoc_pkg::CHROM_W-1:0]   chrom_id_i,
  input  logic [eoc_pkg::PORT_CW-1:0]   range_start_i,
  input  logic [eoc_pkg::PORT_CW-1:0]   range_end_i,
  input  logic [eoc_pkg::TR_W-1:0]      transcript_index_i,
  input  logic [eoc_pkg::SLOT_W-1:0]    exon_slot_i,
  output logic                          result_valid_o,
  output logic [eoc_pkg::TOTAL_W-1:0]   count_value_o,
  output logic [eoc_pkg::HITS_W-1:0]    transcripts_hit_o,
  output logic                          counted_o
);
  import eoc_pkg::*;

  cmd_t         cmd;
  logic         cmd_valid, pop;
  back_status_t status;

  eoc_front #(
    .MAX_EXONS       (MAX_EXONS),
    .MAX_TRANSCRIPTS (MAX_TRANSCRIPTS)
  ) u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .action_i           (action_i),
    .chrom_id_i         (chrom_id_i),
    .range_start_i      (range_start_i),
    .range_end_i        (range_end_i),
    .transcript_index_i (transcript_index_i),
    .exon_slot_i        (exon_slot_i),
    .busy_o             (busy_o),
    .status_i           (status),
    .cmd_valid_o        (cmd_valid),
    .cmd_o              (cmd),
    .pop_i              (pop)
  );

  eoc_back #(
    .MAX_EXONS       (MAX_EXONS),
    .MAX_TRANSCRIPTS (MAX_TRANSCRIPTS),
    .COORD_BITS      (COORD_BITS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_data_i        (cfg_data_i),
    .cmd_valid_i       (cmd_valid),
    .cmd_i             (cmd),
    .pop_o             (pop),
    .status_o          (status),
    .result_valid_o    (result_valid_o),
    .count_value_o     (count_value_o),
    .transcripts_hit_o (transcripts_hit_o),
    .counted_o         (counted_o)
  );

endmodule

>>> dv/exon_overlap_counter_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exon_overlap_counter_core_test
// Self-checking bench: loads exon tables, runs read blocks in both overlap
// modes, queries transcript totals and clears, and compares every result beat
// with an internal per-transcript overlap predictor.
// ----------------------------------------------------------------------------
module exon_overlap_counter_core_test;
  import eoc_pkg::*;

  localparam int unsigned N_EXONS = 4096;
  localparam int unsigned N_TRANS = 1024;
  localparam logic [TOTAL_W-1:0] TOTAL_SAT = '1;

  typedef struct {
    act_e               act;
    logic [CHROM_W-1:0] chrom;
    logic [PORT_CW-1:0] rs;
    logic [PORT_CW-1:0] re;
    logic [TR_W-1:0]    tr;
    logic [SLOT_W-1:0]  slot;
  } cmd_item_t;

  typedef struct {
    logic [TOTAL_W-1:0] count;
    logic [HITS_W-1:0]  hits;
    logic               counted;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_data_i = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic [1:0] action_i = '0;
  logic [CHROM_W-1:0] chrom_id_i = '0;
  logic [PORT_CW-1:0] range_start_i = '0;
  logic [PORT_CW-1:0] range_end_i = '0;
  logic [TR_W-1:0] transcript_index_i = '0;
  logic [SLOT_W-1:0] exon_slot_i = '0;
  logic result_valid_o;
  logic [TOTAL_W-1:0] count_value_o;
  logic [HITS_W-1:0] transcripts_hit_o;
  logic counted_o;

  exon_overlap_counter_core u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i, .start_i, .busy_o,
    .action_i, .chrom_id_i, .range_start_i, .range_end_i,
    .transcript_index_i, .exon_slot_i, .result_valid_o,
    .count_value_o, .transcripts_hit_o, .counted_o
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Predictor state.
  logic [PORT_CW-1:0] exon_lo [N_EXONS];
  logic [PORT_CW-1:0] exon_hi [N_EXONS];
  logic               exon_used [N_EXONS];
  logic [CHROM_W-1:0] exon_chrom [N_EXONS];
  logic [TR_W-1:0]    exon_tr [N_EXONS];
  logic [TOTAL_W-1:0] tr_total [N_TRANS];
  logic               pred_mode = 1'b0;

  cmd_item_t pending_cmds[$];
  outcome_t  expected_beats[$];
  cmd_item_t cur_cmd;
  int gap_left = 0;
  bit quiet = 1'b0;
  int mismatches = 0;

  function automatic void wipe_tables();
    for (int s = 0; s < N_EXONS; s++) exon_used[s] = 1'b0;
    for (int t = 0; t < N_TRANS; t++) tr_total[t] = '0;
  endfunction

  function automatic longint unsigned exon_overlap(int s, logic [CHROM_W-1:0] chrom,
                                                   longint unsigned a0, longint unsigned a1);
    longint unsigned lo, hi;
    if (!exon_used[s] || exon_chrom[s] != chrom) return 0;
    lo = (exon_lo[s] > a0) ? exon_lo[s] : a0;
    hi = (exon_hi[s] < a1) ? exon_hi[s] : a1;
    return (hi > lo) ? hi - lo : 0;
  endfunction

  function automatic outcome_t predict_outcome(cmd_item_t c);
    outcome_t o;
    bit marked [N_TRANS];
    longint unsigned a0, ov, room;
    int hits, only;
    o = '{count: '0, hits: '0, counted: 1'b0};
    case (c.act)
      ACT_LOAD: begin
        exon_lo[c.slot] = c.rs;
        exon_hi[c.slot] = c.re;
        exon_used[c.slot] = 1'b1;
        exon_chrom[c.slot] = c.chrom;
        exon_tr[c.slot] = c.tr;
      end
      ACT_BLOCK: begin
        // Block start is one-based; zero clamps to zero.
        a0 = (c.rs != 0) ? c.rs - 1 : 0;
        hits = 0;
        only = 0;
        for (int s = 0; s < N_EXONS; s++) begin
          if (exon_overlap(s, c.chrom, a0, c.re) > 0 && !marked[exon_tr[s]]) begin
            marked[exon_tr[s]] = 1'b1;
            hits++;
            only = exon_tr[s];
          end
        end
        if (hits > 0 && (pred_mode || hits == 1)) begin
          for (int s = 0; s < N_EXONS; s++) begin
            ov = exon_overlap(s, c.chrom, a0, c.re);
            if (ov > 0 && (pred_mode || exon_tr[s] == only)) begin
              room = TOTAL_SAT - tr_total[exon_tr[s]];
              tr_total[exon_tr[s]] = TOTAL_W'((ov > room) ? TOTAL_SAT
                                                          : tr_total[exon_tr[s]] + ov);
              o.counted = 1'b1;
            end
          end
        end
        o.hits = HITS_W'(hits);
      end
      ACT_READ: o.count = tr_total[c.tr];
      default: wipe_tables();
    endcase
    return o;
  endfunction

  // Driver: start stays high until the beat is taken.
  always @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      expected_beats.push_back(predict_outcome(cur_cmd));
      if (!quiet && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 17);
    end
    if (start_i && busy_o) begin
      // hold the current beat
    end else if (gap_left > 0) begin
      gap_left--;
      start_i <= 1'b0;
    end else if (pending_cmds.size() > 0) begin
      cur_cmd = pending_cmds.pop_front();
      start_i <= 1'b1;
      action_i <= cur_cmd.act;
      chrom_id_i <= cur_cmd.chrom;
      range_start_i <= cur_cmd.rs;
      range_end_i <= cur_cmd.re;
      transcript_index_i <= cur_cmd.tr;
      exon_slot_i <= cur_cmd.slot;
    end else begin
      start_i <= 1'b0;
    end
  end

  // Monitor: every result beat must match the oldest expectation.
  always @(posedge clk_i) begin
    outcome_t e;
    if (rst_ni && result_valid_o) begin
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result beat at %0t", $realtime);
      end else begin
        e = expected_beats.pop_front();
        if (e.count !== count_value_o || e.hits !== transcripts_hit_o ||
            e.counted !== counted_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch at %0t: expected count %0d hits %0d counted %0d, got %0d %0d %0d",
                     $realtime, e.count, e.hits, e.counted,
                     count_value_o, transcripts_hit_o, counted_o);
        end
      end
    end
  end

  function automatic cmd_item_t mk(act_e a, int chrom, logic [31:0] rs, logic [31:0] re,
                                   int tr, int slot);
    cmd_item_t c;
    c.act = a;
    c.chrom = CHROM_W'(chrom);
    c.rs = rs;
    c.re = re;
    c.tr = TR_W'(tr);
    c.slot = SLOT_W'(slot);
    return c;
  endfunction

  function automatic cmd_item_t random_cmd();
    cmd_item_t c;
    int r;
    r = $urandom_range(0, 99);
    c.act = (r < 40) ? ACT_LOAD : (r < 70) ? ACT_BLOCK : (r < 96) ? ACT_READ : ACT_CLEAR;
    if ($urandom_range(0, 9) == 0) begin
      c.chrom = CHROM_W'($urandom);
      c.rs = $urandom;
      c.re = $urandom;
    end else begin
      c.chrom = CHROM_W'($urandom_range(0, 3));
      c.rs = $urandom_range(0, 2000);
      c.re = ($urandom_range(0, 7) == 0) ? c.rs - $urandom_range(0, 20)
                                         : c.rs + $urandom_range(1, 400);
    end
    c.tr = TR_W'(($urandom_range(0, 6) == 0) ? $urandom : $urandom_range(0, 15));
    c.slot = SLOT_W'(($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 63));
    return c;
  endfunction

  task automatic drain();
    while (pending_cmds.size() > 0 || start_i || expected_beats.size() > 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_mode(logic m);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    pred_mode = m;
  endtask

  initial begin
    wipe_tables();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_mode(1'b0);

    // Directed: extremes, start of zero, inverted ranges, multi-hit in single mode.
    pending_cmds.push_back(mk(ACT_LOAD, 1, 32'd100, 32'd200, 3, 0));
    pending_cmds.push_back(mk(ACT_LOAD, 1, 32'd150, 32'd300, 5, 1));
    pending_cmds.push_back(mk(ACT_LOAD, 255, 32'd0, 32'hFFFF_FFFF, 1023, 4095));
    pending_cmds.push_back(mk(ACT_LOAD, 1, 32'd500, 32'd400, 7, 2));
    pending_cmds.push_back(mk(ACT_LOAD, 2, 32'd0, 32'd10, 9, 3));
    pending_cmds.push_back(mk(ACT_BLOCK, 1, 32'd120, 32'd180, 0, 0));
    pending_cmds.push_back(mk(ACT_BLOCK, 1, 32'd160, 32'd190, 0, 0));
    pending_cmds.push_back(mk(ACT_BLOCK, 1, 32'd450, 32'd460, 0, 0));
    pending_cmds.push_back(mk(ACT_BLOCK, 2, 32'd0, 32'd5, 0, 0));
    pending_cmds.push_back(mk(ACT_BLOCK, 2, 32'd8, 32'd3, 0, 0));
    pending_cmds.push_back(mk(ACT_BLOCK, 255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0));
    pending_cmds.push_back(mk(ACT_BLOCK, 0, 32'd120, 32'd180, 0, 0));
    pending_cmds.push_back(mk(ACT_READ, 0, 0, 0, 3, 0));
    pending_cmds.push_back(mk(ACT_READ, 0, 0, 0, 9, 0));
    pending_cmds.push_back(mk(ACT_READ, 0, 0, 0, 1023, 0));
    drain();
    set_mode(1'b1);
    pending_cmds.push_back(mk(ACT_BLOCK, 1, 32'd120, 32'd180, 0, 0));
    pending_cmds.push_back(mk(ACT_BLOCK, 1, 32'd1, 32'hFFFF_FFFF, 0, 0));
    pending_cmds.push_back(mk(ACT_READ, 0, 0, 0, 3, 0));
    pending_cmds.push_back(mk(ACT_READ, 0, 0, 0, 5, 0));
    pending_cmds.push_back(mk(ACT_CLEAR, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk(ACT_READ, 0, 0, 0, 3, 0));
    pending_cmds.push_back(mk(ACT_BLOCK, 1, 32'd120, 32'd180, 0, 0));
    drain();

    // Saturation: sixteen full-width exons of one transcript, hit by seventeen blocks.
    for (int s = 0; s < 16; s++)
      pending_cmds.push_back(mk(ACT_LOAD, 7, 32'd0, 32'hFFFF_FFFF, 42, s));
    for (int b = 0; b < 17; b++)
      pending_cmds.push_back(mk(ACT_BLOCK, 7, (b == 16) ? 32'd0 : 32'd1, 32'hFFFF_FFFF, 0, 0));
    pending_cmds.push_back(mk(ACT_READ, 0, 0, 0, 42, 0));
    pending_cmds.push_back(mk(ACT_CLEAR, 0, 0, 0, 0, 0));
    drain();

    // Random phases in randomly chosen modes, the last in mode 0; the last one has no idling.
    for (int ph = 0; ph < 4; ph++) begin
      set_mode((ph == 3) ? 1'b0 : logic'($urandom_range(0, 1)));
      quiet = (ph == 3);
      for (int i = 0; i < 12; i++) pending_cmds.push_back(random_cmd());
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #120ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
